// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL modules; the training sequencer uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// ===== hw/rtl/lrgd_pkg.sv =====
// Types, codes and fixed-point helpers of the linear regression trainer.
`timescale 1ns / 1ps

package lrgd_pkg;

    localparam int MAX_FW = 6;
    localparam int MAX_SW = 16;

    typedef enum logic [2:0] {
        FUNC_WR_FEATURE = 3'd0,
        FUNC_WR_TARGET  = 3'd1,
        FUNC_TRAIN      = 3'd2,
        FUNC_PREDICT    = 3'd3,
        FUNC_WR_WEIGHT  = 3'd4,
        FUNC_RD_WEIGHT  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        KIND_PREDICT = 2'd0,
        KIND_WEIGHT  = 2'd1,
        KIND_DONE    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [2:0]         func;
        logic [9:0]         sample_index;
        logic [3:0]         feature_index;
        logic signed [31:0] value;
        logic               last;
    } t_request;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] result_value;
        logic               class_bit;
    } t_result;

    // Commands from the training sequencer to the datapath.
    typedef struct packed {
        logic              train;
        logic              rd_en;
        logic [MAX_SW-1:0] samp_j;
        logic [MAX_FW-1:0] feat_k;
        logic [MAX_FW-1:0] feat_i;
        logic              err_en;
        logic              grad_en;
        logic              step1;
        logic              step2;
        logic              step3;
        logic              done;
    } t_cmd;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        if (x < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

// ===== hw/rtl/lrgd_ctrl.sv =====
// Training sequencer: walks passes, features, samples and dot product elements.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrgd_ctrl #(
    parameter int MAX_FEATURES = 16,
    parameter int MAX_SAMPLES  = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_train,
    input  logic [4:0]       i_feature_count,
    input  logic [10:0]      i_sample_count,
    input  logic [15:0]      i_iteration_count,
    output logic             o_busy,
    output lrgd_pkg::t_cmd   o_cmd
);

    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DOT, ST_W1, ST_W2, ST_ERR, ST_GRAD, ST_GW,
        ST_STEP1, ST_STEP2, ST_STEP3, ST_DONE
    } t_state;

    t_state        r_state;
    logic [FW-1:0] r_k, r_i;
    logic [SW-1:0] r_j;
    logic [15:0]   r_it;
    int            nf, ns;

    always_comb begin
        nf = (int'(i_feature_count) < MAX_FEATURES) ? int'(i_feature_count) : MAX_FEATURES;
        ns = (int'(i_sample_count) < MAX_SAMPLES) ? int'(i_sample_count) : MAX_SAMPLES;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_it    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_train) begin
                        r_k  <= '0;
                        r_i  <= '0;
                        r_j  <= '0;
                        r_it <= '0;
                        if (i_iteration_count == 16'd0 || nf == 0) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= (ns == 0) ? ST_STEP1 : ST_DOT;
                        end
                    end
                end
                ST_DOT: begin
                    if (int'(r_k) == nf - 1) begin
                        r_k     <= '0;
                        r_state <= ST_W1;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_W1:   r_state <= ST_W2;
                ST_W2:   r_state <= ST_ERR;
                ST_ERR:  r_state <= ST_GRAD;
                ST_GRAD: begin
                    if (int'(r_j) == ns - 1) begin
                        r_j     <= '0;
                        r_state <= ST_GW;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_DOT;
                    end
                end
                ST_GW:    r_state <= ST_STEP1;
                ST_STEP1: r_state <= ST_STEP2;
                ST_STEP2: r_state <= ST_STEP3;
                ST_STEP3: begin
                    if (int'(r_i) == nf - 1) begin
                        r_i <= '0;
                        if (r_it == i_iteration_count - 16'd1) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_it    <= r_it + 16'd1;
                            r_state <= (ns == 0) ? ST_STEP1 : ST_DOT;
                        end
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= (ns == 0) ? ST_STEP1 : ST_DOT;
                    end
                end
                ST_DONE: r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.train   = (r_state != ST_IDLE);
        o_cmd.rd_en   = (r_state == ST_DOT);
        o_cmd.samp_j  = lrgd_pkg::MAX_SW'(r_j);
        o_cmd.feat_k  = lrgd_pkg::MAX_FW'(r_k);
        o_cmd.feat_i  = lrgd_pkg::MAX_FW'(r_i);
        o_cmd.err_en  = (r_state == ST_ERR);
        o_cmd.grad_en = (r_state == ST_GRAD);
        o_cmd.step1   = (r_state == ST_STEP1);
        o_cmd.step2   = (r_state == ST_STEP2);
        o_cmd.step3   = (r_state == ST_STEP3);
        o_cmd.done    = (r_state == ST_DONE);
    end

    assign o_busy = (r_state != ST_IDLE);

    `ASSERT_CLK(a_train_goes_busy, i_clk, i_rst_n, (i_train && !o_busy) |=> o_busy, "train request did not start the sequencer")
    `ASSERT_CLK(a_done_then_idle, i_clk, i_rst_n, o_cmd.done |=> !o_busy, "sequencer did not return to idle after done")
    `ASSERT_CLK(a_one_cmd, i_clk, i_rst_n, $onehot0({o_cmd.rd_en, o_cmd.err_en, o_cmd.grad_en, o_cmd.step1, o_cmd.step2, o_cmd.step3, o_cmd.done}), "more than one datapath command at once")

endmodule

// ===== hw/rtl/lrgd_dp.sv =====
// Datapath: sample and target memories, weights, shared multiplier and accumulators.
`timescale 1ns / 1ps

module lrgd_dp #(
    parameter int MAX_FEATURES = 16,
    parameter int MAX_SAMPLES  = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  lrgd_pkg::t_request  i_req,
    input  lrgd_pkg::t_cmd      i_cmd,
    input  logic [23:0]         i_step_scale,
    output logic                o_valid,
    output lrgd_pkg::t_result   o_result
);

    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SDEPTH = MAX_SAMPLES * (2 ** FW);

    typedef enum logic [2:0] {
        TAG_NONE, TAG_PRED, TAG_DOT, TAG_GRAD, TAG_WRD, TAG_DONE
    } t_tag;

    logic signed [31:0] smem [SDEPTH];
    logic signed [31:0] tmem [MAX_SAMPLES];
    logic signed [31:0] r_w  [MAX_FEATURES];

    logic signed [31:0] r_x, r_tdata, r_xi, r_err;
    logic [FW-1:0]      r_k1;
    logic               r_xv1;
    t_tag               r_tag;
    logic signed [63:0] r_prod;
    logic               r_last;
    logic signed [63:0] r_acc, r_dacc, r_grad;
    logic [55:0]        r_ma, r_mb;
    logic               r_neg;
    logic [47:0]        r_d;
    logic               r_valid;
    lrgd_pkg::t_result  r_result;

    logic [31:0]        si32, fi32;
    logic               si_ok, fi_ok;
    logic [SW-1:0]      si_a;
    logic [FW-1:0]      fi_a, w_ra, fk, fi_t;
    logic [SW-1:0]      sj;
    logic signed [31:0] w_rd, w_sel;
    logic signed [31:0] mul_a, mul_b;
    t_tag               tag_in;
    logic signed [63:0] acc_new, grad_mag_src;
    logic [63:0]        mag;
    logic signed [31:0] pred_r, dot32;
    logic [56:0]        low_sum;
    logic signed [63:0] w_upd;

    always_comb begin
        si32  = 32'(i_req.sample_index);
        fi32  = 32'(i_req.feature_index);
        si_ok = si32 < 32'(MAX_SAMPLES);
        fi_ok = fi32 < 32'(MAX_FEATURES);
        si_a  = si32[SW-1:0];
        fi_a  = fi32[FW-1:0];
        fk    = i_cmd.feat_k[FW-1:0];
        fi_t  = i_cmd.feat_i[FW-1:0];
        sj    = i_cmd.samp_j[SW-1:0];
        if (r_xv1) begin
            w_ra = r_k1;
        end else if (i_cmd.train) begin
            w_ra = fi_t;
        end else begin
            w_ra = fi_a;
        end
        w_rd  = r_w[w_ra];
        w_sel = (fi_ok || i_cmd.train) ? w_rd : 32'sd0;

        tag_in = TAG_NONE;
        mul_a  = w_sel;
        mul_b  = i_req.value;
        if (r_xv1) begin
            tag_in = TAG_DOT;
            mul_b  = r_x;
        end else if (i_cmd.grad_en) begin
            tag_in = TAG_GRAD;
            mul_a  = r_err;
            mul_b  = r_xi;
        end else if (i_cmd.done) begin
            tag_in = TAG_DONE;
        end else if (i_accept && i_req.func == lrgd_pkg::FUNC_PREDICT) begin
            tag_in = TAG_PRED;
        end else if (i_accept && i_req.func == lrgd_pkg::FUNC_RD_WEIGHT) begin
            tag_in = TAG_WRD;
        end

        acc_new = lrgd_pkg::sat_add64(r_acc, r_prod);
        pred_r  = lrgd_pkg::sat32(acc_new >>> 16);
        dot32   = lrgd_pkg::sat32(r_dacc >>> 16);

        grad_mag_src = r_grad;
        mag     = r_grad[63] ? (64'd0 - 64'(grad_mag_src)) : 64'(grad_mag_src);
        low_sum = 57'({r_ma[7:0], 32'd0}) + 57'(r_mb);
        w_upd   = r_neg ? (64'(w_rd) + 64'(r_d)) : (64'(w_rd) - 64'(r_d));
    end

    // Memories: host writes while idle, training reads.
    always_ff @(posedge i_clk) begin
        if (i_accept && i_req.func == lrgd_pkg::FUNC_WR_FEATURE && si_ok && fi_ok) begin
            smem[{si_a, fi_a}] <= i_req.value;
        end
        if (i_accept && i_req.func == lrgd_pkg::FUNC_WR_TARGET && si_ok) begin
            tmem[si_a] <= i_req.value;
        end
        r_x     <= smem[{sj, fk}];
        r_tdata <= tmem[sj];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < MAX_FEATURES; n++) begin
                r_w[n] <= 32'sd0;
            end
            r_xv1   <= 1'b0;
            r_tag   <= TAG_NONE;
            r_acc   <= '0;
            r_dacc  <= '0;
            r_grad  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_xv1 <= i_cmd.rd_en;
            r_k1  <= fk;
            r_tag <= tag_in;
            r_last <= i_req.last;
            if (tag_in == TAG_WRD) begin
                r_prod <= 64'(w_sel);
            end else if (tag_in == TAG_PRED && !fi_ok) begin
                r_prod <= '0;
            end else begin
                r_prod <= mul_a * mul_b;
            end
            if (r_xv1 && r_k1 == fi_t) begin
                r_xi <= r_x;
            end

            if (i_accept && i_req.func == lrgd_pkg::FUNC_WR_WEIGHT && fi_ok) begin
                r_w[fi_a] <= i_req.value;
            end
            if (i_cmd.step3) begin
                r_w[fi_t] <= lrgd_pkg::sat32(w_upd);
                r_grad    <= '0;
            end

            if (i_cmd.err_en) begin
                r_err  <= lrgd_pkg::sat32(64'(dot32) - 64'(r_tdata));
                r_dacc <= '0;
            end
            if (i_cmd.step1) begin
                r_ma  <= mag[63:32] * i_step_scale;
                r_mb  <= mag[31:0] * i_step_scale;
                r_neg <= r_grad[63];
            end
            if (i_cmd.step2) begin
                r_d <= 48'(r_ma >> 8) + 48'(low_sum >> 40);
            end

            r_valid <= 1'b0;
            case (r_tag)
                TAG_PRED: begin
                    r_acc <= r_last ? 64'sd0 : acc_new;
                    if (r_last) begin
                        r_valid               <= 1'b1;
                        r_result.kind         <= lrgd_pkg::KIND_PREDICT;
                        r_result.result_value <= pred_r;
                        r_result.class_bit    <= ~pred_r[31];
                    end
                end
                TAG_DOT:  r_dacc <= lrgd_pkg::sat_add64(r_dacc, r_prod);
                TAG_GRAD: r_grad <= lrgd_pkg::sat_add64(r_grad, r_prod);
                TAG_WRD: begin
                    r_valid               <= 1'b1;
                    r_result.kind         <= lrgd_pkg::KIND_WEIGHT;
                    r_result.result_value <= r_prod[31:0];
                    r_result.class_bit    <= 1'b0;
                end
                TAG_DONE: begin
                    r_valid               <= 1'b1;
                    r_result.kind         <= lrgd_pkg::KIND_DONE;
                    r_result.result_value <= 32'sd0;
                    r_result.class_bit    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/linear_regression_gd_trainer.sv =====
// Top level of the linear regression gradient-descent trainer and predictor.
`timescale 1ns / 1ps

// Load, predict and weight requests are taken one per clock while busy is low. Each result
// is flagged by o_result_strobe, high for a single cycle, with o_result registered from its
// request through the product and result registers; the receiver cannot stall the block,
// so it must take every strobe. A train request holds busy high while the sequencer walks
// the stored data, reading dot products through the single sample memory read port, which
// delivers one feature element per cycle. The training-finished result is raised from the
// done state through the tag and result registers. The user must write configuration
// through i_cfg_wr_en, i_cfg_index and i_cfg_data only while the block is idle; the block
// itself does not enforce this.

module linear_regression_gd_trainer #(
    parameter int MAX_FEATURES = 16,
    parameter int MAX_SAMPLES  = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  lrgd_pkg::t_request i_request,
    output logic               o_result_strobe,
    output lrgd_pkg::t_result  o_result,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    localparam logic [1:0] CFG_FEATURES   = 2'd0;
    localparam logic [1:0] CFG_SAMPLES    = 2'd1;
    localparam logic [1:0] CFG_STEP_SCALE = 2'd2;
    localparam logic [1:0] CFG_ITERATIONS = 2'd3;

    logic [4:0]     r_feature_count;
    logic [10:0]    r_sample_count;
    logic [23:0]    r_step_scale;
    logic [15:0]    r_iteration_count;
    logic           accept;
    lrgd_pkg::t_cmd cmd;

    // Configuration registers take the low bits of the written data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_count   <= 5'd16;
            r_sample_count    <= 11'd1024;
            r_step_scale      <= 24'd16777;
            r_iteration_count <= 16'd1000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FEATURES:   r_feature_count   <= i_cfg_data[4:0];
                CFG_SAMPLES:    r_sample_count    <= i_cfg_data[10:0];
                CFG_STEP_SCALE: r_step_scale      <= i_cfg_data;
                CFG_ITERATIONS: r_iteration_count <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // A request is taken whenever start is high and the sequencer is idle.
    assign accept = start && !busy;

    lrgd_ctrl #(
        .MAX_FEATURES(MAX_FEATURES),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_train          (accept && i_request.func == lrgd_pkg::FUNC_TRAIN),
        .i_feature_count  (r_feature_count),
        .i_sample_count   (r_sample_count),
        .i_iteration_count(r_iteration_count),
        .o_busy           (busy),
        .o_cmd            (cmd)
    );

    lrgd_dp #(
        .MAX_FEATURES(MAX_FEATURES),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (i_request),
        .i_cmd       (cmd),
        .i_step_scale(r_step_scale),
        .o_valid     (o_result_strobe),
        .o_result    (o_result)
    );

endmodule
